### rtl/mact_pkg.sv
// ----------------------------------------------------------------------------
// mact_pkg
// shared types and constants for the moving average crossover block
// ----------------------------------------------------------------------------
package mact_pkg;

  localparam int HistDepth = 20;
  localparam int HistW = $clog2(HistDepth);
  localparam logic [4:0] RunMax = 5'd31;
  localparam logic [47:0] EqOne = 48'h0001_0000_0000;
  localparam logic [47:0] EqMax = 48'hFFFF_FFFF_FFFF;

  // ceil(2^37 / 5), exact floor(x / 5) for x below 2^35
  localparam logic [34:0] Recip5 = 35'd27487790695;

  localparam logic [1:0] RegBuy = 2'd0;
  localparam logic [1:0] RegSell = 2'd1;
  localparam logic [1:0] RegRise = 2'd2;

  localparam logic [2:0] EvNone = 3'd0;
  localparam logic [2:0] EvBuy = 3'd1;
  localparam logic [2:0] EvSell = 3'd2;
  localparam logic [2:0] EvForced = 3'd3;
  localparam logic [2:0] EvBuyForced = 3'd4;

  // classified bar passed from front to back
  typedef struct packed {
    logic [31:0] close;
    logic        enable;
    logic        final_b;
    logic [34:0] s5;
    logic [35:0] s10;
    logic [36:0] s20;
    logic        v5;
    logic        v10;
    logic        v20;
    logic        below;
    logic        rising;
    logic        rise_ok;
    logic [4:0]  run_before;
  } bar_t;

  typedef struct packed {
    logic [31:0] avg_five;
    logic        avg_five_valid;
    logic [31:0] avg_ten;
    logic        avg_ten_valid;
    logic [31:0] avg_twenty;
    logic        avg_twenty_valid;
    logic [2:0]  trade_event;
    logic [15:0] trades_done;
    logic [47:0] equity_value;
    logic        holding;
  } res_t;

endpackage

### rtl/ma_crossover_trade_signal.sv
// ----------------------------------------------------------------------------
// ma_crossover_trade_signal
// moving average crossover trade signal over a stream of daily closes
// ----------------------------------------------------------------------------
// in_ channel takes one bar per word: close price on tdata, trade enable on
// tuser, final bar of the window on tlast.
// out_ channel returns one result word per bar: three moving averages with
// valid flags, trade event, round trip count, equity (Q16.32) and holding.
// cfg_ is an APB style port for the day counts and the rise limit; write
// only while no bar is in flight.
// the front sums the 20 bar history one entry a cycle and takes no new bar
// until it has handed the last one on; it hands a classified bar to the back
// through a two entry queue. the back divides the three sums by reciprocal
// multiply and, on an exit, scales equity with a one bit per cycle 80 bit
// divider. the back takes no new bar until its last result has been taken.
// reset clears history, counters and equity to one; registers go to 3, 1, 990.
// a stalled receiver holds the result; the queue then fills and in_tready drops.
// ----------------------------------------------------------------------------
module ma_crossover_trade_signal import mact_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // close_price
  input  logic        in_tuser,  // trade_enable
  input  logic        in_tlast,  // final_bar
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [167:0] out_tdata, // avg_five, avg_five_valid, avg_ten, avg_ten_valid,
                                 // avg_twenty, avg_twenty_valid, trade_event,
                                 // trades_done, equity_value, holding, zero fill
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [4:0]  buy_r, sell_r;
  logic [13:0] rise_r;
  logic fv, fr, qv, qr;
  bar_t fb, qb;
  res_t rs;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buy_r <= 5'd3;
      sell_r <= 5'd1;
      rise_r <= 14'd990;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr[3:2])
        RegBuy:  buy_r <= cfg_pwdata[4:0];
        RegSell: sell_r <= cfg_pwdata[4:0];
        RegRise: rise_r <= cfg_pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      RegBuy:  cfg_prdata = {27'd0, buy_r};
      RegSell: cfg_prdata = {27'd0, sell_r};
      RegRise: cfg_prdata = {18'd0, rise_r};
      default: cfg_prdata = '0;
    endcase
  end

  mact_front u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .close_price(in_tdata), .trade_enable(in_tuser),
    .final_bar(in_tlast), .max_rise(rise_r),
    .bar_valid(fv), .bar_ready(fr), .bar(fb)
  );

  mact_fifo u_fifo (
    .clk, .rst_n,
    .wr_valid(fv), .wr_ready(fr), .wr_data(fb),
    .rd_valid(qv), .rd_ready(qr), .rd_data(qb)
  );

  mact_back u_back (
    .clk, .rst_n,
    .bar_valid(qv), .bar_ready(qr), .bar(qb),
    .buy_days(buy_r), .sell_days(sell_r),
    .res_valid(out_tvalid), .res_ready(out_tready), .res(rs)
  );

  assign out_tdata = {1'b0, rs.holding, rs.equity_value, rs.trades_done, rs.trade_event,
                      rs.avg_twenty_valid, rs.avg_twenty, rs.avg_ten_valid, rs.avg_ten,
                      rs.avg_five_valid, rs.avg_five};

endmodule

### rtl/mact_front.sv
// ----------------------------------------------------------------------------
// mact_front
// close history, window sums and bar classification, one step per cycle unless waiting on the queue
// ----------------------------------------------------------------------------
module mact_front import mact_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] close_price,
  input  logic        trade_enable,
  input  logic        final_bar,
  input  logic [13:0] max_rise,
  output logic        bar_valid,
  input  logic        bar_ready,
  output bar_t        bar
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_SUM  = 4'b0010,
    F_CLS  = 4'b0100,
    F_OUT  = 4'b1000
  } fst_t;

  fst_t st_r, st_nxt;
  logic [31:0] hist_r [HistDepth];
  logic [4:0]  bars_r;
  logic [4:0]  run_r;
  logic [34:0] prev_s5_r;
  logic [HistW-1:0] idx_r;
  logic [36:0] acc_r;
  logic [34:0] s5_r;
  logic [35:0] s10_r;
  logic [31:0] close_r, prev_close_r;
  logic        en_r, fin_r;
  logic [4:0]  before_r;
  bar_t        bar_r;

  // rise test operands, registered after multiply
  logic [45:0] lhs_r;
  logic [46:0] rhs_r;

  assign in_ready = (st_r == F_IDLE);
  assign bar_valid = (st_r == F_OUT);
  assign bar = bar_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      F_IDLE: if (in_valid) st_nxt = F_SUM;
      F_SUM:  if (idx_r == HistW'(HistDepth - 1)) st_nxt = F_CLS;
      F_CLS:  st_nxt = F_OUT;
      F_OUT:  if (bar_ready) st_nxt = F_IDLE;
      default: st_nxt = F_IDLE;
    endcase
  end

  logic [36:0] acc_nxt;
  logic [34:0] c5;
  assign acc_nxt = acc_r + 37'(hist_r[idx_r]);
  assign c5 = 35'(close_r) * 35'd5;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
      bars_r <= '0;
      run_r <= '0;
      prev_s5_r <= '0;
      for (int i = 0; i < HistDepth; i++) hist_r[i] <= '0;
    end else begin
      st_r <= st_nxt;
      unique case (st_r)
        F_IDLE: if (in_valid) begin
          for (int i = HistDepth - 1; i > 0; i--) hist_r[i] <= hist_r[i-1];
          hist_r[0] <= close_price;
          prev_close_r <= hist_r[0];
          close_r <= close_price;
          en_r <= trade_enable;
          fin_r <= final_bar;
          before_r <= bars_r;
          if (bars_r != RunMax) bars_r <= bars_r + 5'd1;
          idx_r <= '0;
          acc_r <= '0;
        end
        F_SUM: begin
          acc_r <= acc_nxt;
          idx_r <= idx_r + HistW'(1);
          if (idx_r == HistW'(4)) s5_r <= acc_nxt[34:0];
          if (idx_r == HistW'(9)) s10_r <= acc_nxt[35:0];
          lhs_r <= 46'(close_r) * 46'd10000;
          rhs_r <= 47'(15'd10000 + 15'(max_rise)) * 47'(prev_close_r);
        end
        F_CLS: begin
          bar_r.close <= close_r;
          bar_r.enable <= en_r;
          bar_r.final_b <= fin_r;
          bar_r.s5 <= s5_r;
          bar_r.s10 <= s10_r;
          bar_r.s20 <= acc_r;
          bar_r.v5 <= bars_r >= 5'd5;
          bar_r.v10 <= bars_r >= 5'd10;
          bar_r.v20 <= bars_r >= 5'd20;
          bar_r.below <= (bars_r >= 5'd5) && (c5 < s5_r);
          bar_r.rising <= (before_r >= 5'd5) && (s5_r > prev_s5_r);
          bar_r.rise_ok <= (prev_close_r != '0) && (47'(lhs_r) <= rhs_r);
          bar_r.run_before <= run_r;
          if (fin_r) begin
            for (int i = 0; i < HistDepth; i++) hist_r[i] <= '0;
            bars_r <= '0;
            run_r <= '0;
            prev_s5_r <= '0;
          end else begin
            prev_s5_r <= s5_r;
            if ((bars_r >= 5'd5) && (c5 < s5_r))
              run_r <= (run_r != RunMax) ? run_r + 5'd1 : RunMax;
            else
              run_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### rtl/mact_fifo.sv
// ----------------------------------------------------------------------------
// mact_fifo
// two entry queue of classified bars between front and back
// ----------------------------------------------------------------------------
module mact_fifo import mact_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  bar_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output bar_t rd_data
);

  bar_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr_valid && wr_ready) begin
        mem_r[wp_r] <= wr_data;
        wp_r <= ~wp_r;
      end
      if (rd_valid && rd_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end

`ifndef SYNTHESIS
  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !wr_ready) else $error("queue overflow");
  a_cnt_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_valid && rd_ready && !wr_valid) |=> cnt_r == $past(cnt_r) - 2'd1)
    else $error("queue pop lost");
`endif

endmodule

### rtl/mact_back.sv
// ----------------------------------------------------------------------------
// mact_back
// trade rule, averages, iterative equity scaling and result register
// ----------------------------------------------------------------------------
module mact_back import mact_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        bar_valid,
  output logic        bar_ready,
  input  bar_t        bar,
  input  logic [4:0]  buy_days,
  input  logic [4:0]  sell_days,
  output logic        res_valid,
  input  logic        res_ready,
  output res_t        res
);

  typedef enum logic [6:0] {
    B_IDLE = 7'b0000001,
    B_DEC  = 7'b0000010,
    B_MUL0 = 7'b0000100,
    B_MUL1 = 7'b0001000,
    B_DIV  = 7'b0010000,
    B_AVG  = 7'b0100000,
    B_OUT  = 7'b1000000
  } bst_t;

  bst_t st_r;
  bar_t b_r;
  logic        in_trade_r;
  logic [31:0] entry_r;
  logic [47:0] eq_r;
  logic [15:0] total_r;
  logic [2:0]  ev_r;
  logic [79:0] prod_r;
  logic [63:0] lo_r;
  logic [79:0] quo_r;
  logic [32:0] rem_r;
  logic [6:0]  cnt_r;
  logic [1:0]  avg_sel_r;
  logic        avg_ph_r;
  logic [52:0] plo_r;
  logic [51:0] phi_r;
  res_t        res_r;

  // average = floor(sum / 5) after dropping the power of two part of n
  logic [34:0] dnum;
  logic [69:0] dsum;
  logic [31:0] dquo;
  always_comb begin
    unique case (avg_sel_r)
      2'd0: dnum = b_r.s5;
      2'd1: dnum = b_r.s10[35:1];
      default: dnum = b_r.s20[36:2];
    endcase
  end
  assign dsum = 70'(plo_r) + {phi_r, 18'd0};
  assign dquo = dsum[68:37];

  logic [33:0] etry;
  assign etry = {rem_r, quo_r[79]} - {2'b0, entry_r};

  logic win_ok, sell_ok, do_buy, do_sell;
  logic [4:0] run_now;
  assign run_now = b_r.below ? ((b_r.run_before != RunMax) ? b_r.run_before + 5'd1 : RunMax)
                             : 5'd0;
  assign win_ok = buy_days != '0 && b_r.run_before >= buy_days;
  assign sell_ok = sell_days != '0 && run_now >= sell_days;
  assign do_buy = b_r.enable && b_r.v5 && !in_trade_r && win_ok &&
                  (35'(b_r.close) * 35'd5 > b_r.s5) && b_r.rising && b_r.rise_ok;
  assign do_sell = b_r.enable && b_r.v5 && !do_buy && in_trade_r && sell_ok;

  assign bar_ready = st_r == B_IDLE;
  assign res_valid = st_r == B_OUT;
  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      in_trade_r <= 1'b0;
      entry_r <= '0;
      eq_r <= EqOne;
      total_r <= '0;
    end else begin
      unique case (st_r)
        B_IDLE: if (bar_valid) begin
          b_r <= bar;
          st_r <= B_DEC;
        end
        B_DEC: begin
          if (do_buy) begin
            in_trade_r <= 1'b1;
            entry_r <= b_r.close;
            ev_r <= b_r.final_b ? EvBuyForced : EvBuy;
          end else if (do_sell) begin
            ev_r <= EvSell;
          end else begin
            ev_r <= (b_r.final_b && in_trade_r) ? EvForced : EvNone;
          end
          if (do_sell || (b_r.final_b && (in_trade_r || do_buy)))
            st_r <= B_MUL0;
          else begin
            st_r <= B_AVG;
          end
          avg_sel_r <= 2'd0;
          avg_ph_r <= 1'b0;
        end
        B_MUL0: begin
          lo_r <= 64'(eq_r[31:0]) * 64'(b_r.close);
          st_r <= B_MUL1;
        end
        B_MUL1: begin
          prod_r <= {(48'(eq_r[47:32]) * 48'(b_r.close)) + 48'(lo_r[63:32]), lo_r[31:0]};
          st_r <= B_DIV;
          cnt_r <= '0;
          rem_r <= '0;
        end
        B_DIV: begin
          if (cnt_r == 7'd0) begin
            quo_r <= prod_r;
            cnt_r <= 7'd1;
          end else begin
            if (!etry[33]) begin
              rem_r <= etry[32:0];
              quo_r <= {quo_r[78:0], 1'b1};
            end else begin
              rem_r <= {rem_r[31:0], quo_r[79]};
              quo_r <= {quo_r[78:0], 1'b0};
            end
            cnt_r <= cnt_r + 7'd1;
            if (cnt_r == 7'd80) begin
              if (entry_r != '0)
                eq_r <= (quo_r[78:47] != '0) ? EqMax
                       : (etry[33] ? {quo_r[46:0], 1'b0} : {quo_r[46:0], 1'b1});
              in_trade_r <= 1'b0;
              if (total_r != 16'hFFFF) total_r <= total_r + 16'd1;
              st_r <= B_AVG;
            end
          end
        end
        B_AVG: begin
          if (!avg_ph_r) begin
            plo_r <= 53'(dnum) * 53'(Recip5[17:0]);
            phi_r <= 52'(dnum) * 52'(Recip5[34:18]);
            avg_ph_r <= 1'b1;
          end else begin
            avg_ph_r <= 1'b0;
            unique case (avg_sel_r)
              2'd0: begin
                res_r.avg_five <= b_r.v5 ? dquo : '0;
                avg_sel_r <= 2'd1;
              end
              2'd1: begin
                res_r.avg_ten <= b_r.v10 ? dquo : '0;
                avg_sel_r <= 2'd2;
              end
              default: begin
                res_r.avg_twenty <= b_r.v20 ? dquo : '0;
                res_r.avg_five_valid <= b_r.v5;
                res_r.avg_ten_valid <= b_r.v10;
                res_r.avg_twenty_valid <= b_r.v20;
                res_r.trade_event <= ev_r;
                res_r.trades_done <= total_r;
                res_r.equity_value <= eq_r;
                res_r.holding <= in_trade_r && !b_r.final_b;
                if (b_r.final_b) begin
                  in_trade_r <= 1'b0;
                  entry_r <= '0;
                  eq_r <= EqOne;
                  total_r <= '0;
                end
                st_r <= B_OUT;
              end
            endcase
          end
        end
        B_OUT: if (res_ready) st_r <= B_IDLE;
        default: st_r <= B_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> res_valid) else $error("result dropped");
  a_eq_nz: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == B_IDLE |-> (in_trade_r || eq_r != '0 || total_r != '0))
    else $error("equity cleared while idle without trades");
  a_ev_ok: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> res_r.trade_event <= EvBuyForced)
    else $error("trade event out of range");
`endif

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the moving average crossover trade signal block
// ----------------------------------------------------------------------------
// drives bars on the in_ stream and compares every out_ word with a local
// prediction of the averages, trade events, round trip count and equity.
// phases cycle through register settings and sender/receiver idling patterns,
// and one long receiver hold-off forces the block to back up its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import mact_pkg::*;

  class trade_board;
    logic [31:0] hist [HistDepth];
    logic [4:0]  bars;
    logic [4:0]  run;
    logic [34:0] psum;
    logic        pos_open;
    logic [31:0] entry;
    logic [47:0] eq;
    logic [15:0] total;
    logic [4:0]  buy_days;
    logic [4:0]  sell_days;
    logic [13:0] rise_max;
    res_t        pending [$];
    int          errors;
    int          checked;
    int          n_buy, n_sell, n_forced, n_both, n_sat;

    function void clear();
      foreach (hist[k]) hist[k] = '0;
      bars = '0; run = '0; psum = '0; pos_open = 1'b0; entry = '0;
      eq = EqOne; total = '0;
    endfunction

    function new();
      clear();
      buy_days = 5'd3; sell_days = 5'd1; rise_max = 14'd990;
      errors = 0; checked = 0;
      n_buy = 0; n_sell = 0; n_forced = 0; n_both = 0; n_sat = 0;
    endfunction

    function void close_out(logic [31:0] c);
      logic [79:0] prod;
      logic [79:0] quo;
      if (entry != 0) begin
        prod = eq * c;
        quo = prod / entry;
        if (quo > {32'd0, EqMax}) begin
          eq = EqMax;
          n_sat++;
        end else begin
          eq = quo[47:0];
        end
      end
      pos_open = 1'b0;
      if (total != 16'hFFFF) total++;
    endfunction

    function void note_bar(logic [31:0] c, logic en, logic fin);
      logic [4:0]  seen_before;
      logic [31:0] prev_c;
      logic [4:0]  run_before;
      logic [63:0] s5, s10, s20, c5;
      logic        v5, v10, v20, win_ok, rising, rise_ok, sell_ok;
      logic [2:0]  ev;
      res_t        r;
      seen_before = bars; prev_c = hist[0]; run_before = run; ev = EvNone;
      for (int k = HistDepth - 1; k > 0; k--) hist[k] = hist[k-1];
      hist[0] = c;
      if (bars != RunMax) bars++;
      s5 = 0; s10 = 0; s20 = 0;
      for (int k = 0; k < 20; k++) begin
        if (k < 5) s5 += hist[k];
        if (k < 10) s10 += hist[k];
        s20 += hist[k];
      end
      v5 = bars >= 5; v10 = bars >= 10; v20 = bars >= 20;
      c5 = 64'(c) * 5;
      if (v5 && c5 < s5) run = (run != RunMax) ? run + 5'd1 : RunMax;
      else run = '0;
      if (en && v5) begin
        win_ok = buy_days != 0 && run_before >= buy_days;
        rising = seen_before >= 5 && s5 > 64'(psum);
        rise_ok = prev_c != 0 &&
          64'(c) * 10000 <= (64'd10000 + 64'(rise_max)) * 64'(prev_c);
        sell_ok = sell_days != 0 && run >= sell_days;
        if (!pos_open && win_ok && c5 > s5 && rising && rise_ok) begin
          pos_open = 1'b1; entry = c; ev = EvBuy;
        end else if (pos_open && sell_ok) begin
          close_out(c); ev = EvSell;
        end
      end
      psum = s5[34:0];
      if (fin && pos_open) begin
        close_out(c);
        ev = (ev == EvBuy) ? EvBuyForced : EvForced;
      end
      case (ev)
        EvBuy: n_buy++;
        EvSell: n_sell++;
        EvForced: n_forced++;
        EvBuyForced: n_both++;
        default: ;
      endcase
      r.avg_five = v5 ? 32'(s5 / 5) : '0;
      r.avg_five_valid = v5;
      r.avg_ten = v10 ? 32'(s10 / 10) : '0;
      r.avg_ten_valid = v10;
      r.avg_twenty = v20 ? 32'(s20 / 20) : '0;
      r.avg_twenty_valid = v20;
      r.trade_event = ev;
      r.trades_done = total;
      r.equity_value = eq;
      r.holding = pos_open;
      pending.insert(pending.size(), r);
      if (fin) clear();
    endfunction

    function void check_result(res_t got);
      res_t want;
      logic bad;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word: %p", got);
        return;
      end
      want = pending.pop_front();
      checked++;
      bad = want.avg_five != got.avg_five || want.avg_five_valid != got.avg_five_valid ||
            want.avg_ten != got.avg_ten || want.avg_ten_valid != got.avg_ten_valid ||
            want.avg_twenty != got.avg_twenty ||
            want.avg_twenty_valid != got.avg_twenty_valid ||
            want.trade_event != got.trade_event || want.trades_done != got.trades_done ||
            want.equity_value != got.equity_value || want.holding != got.holding;
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch on result %0d", checked);
          $display("  expected %p", want);
          $display("  actual   %p", got);
        end
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [31:0]  in_tdata = '0;  // close_price
  logic         in_tuser = 1'b0; // trade_enable
  logic         in_tlast = 1'b0; // final_bar
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [167:0] out_tdata;      // avg_five, avg_five_valid, avg_ten, avg_ten_valid,
                                // avg_twenty, avg_twenty_valid, trade_event,
                                // trades_done, equity_value, holding, zero fill
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [3:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  trade_board sb = new();
  int  idle_mode = 0;
  int  hold_req = 0;
  int  idle_cycles = 0;
  int  words_in = 0;
  logic [31:0] walk_price = 32'd100000;
  int  seg_left = 0;
  bit  walk_down = 1'b1;

  ma_crossover_trade_signal u_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // monitor and scoreboard feed
  always @(posedge clk) begin
    res_t got;
    if (rst_n && in_tvalid && in_tready) begin
      sb.note_bar(in_tdata, in_tuser, in_tlast);
      words_in++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.avg_five = out_tdata[31:0];
      got.avg_five_valid = out_tdata[32];
      got.avg_ten = out_tdata[64:33];
      got.avg_ten_valid = out_tdata[65];
      got.avg_twenty = out_tdata[97:66];
      got.avg_twenty_valid = out_tdata[98];
      got.trade_event = out_tdata[101:99];
      got.trades_done = out_tdata[117:102];
      got.equity_value = out_tdata[165:118];
      got.holding = out_tdata[166];
      sb.check_result(got);
    end
  end

  // receiver with random stalls and one long hold-off on request
  always @(posedge clk) begin
    if (hold_req > 0) begin
      out_tready <= 1'b0;
      hold_req <= hold_req - 1;
    end else if (idle_mode == 2) begin
      out_tready <= $urandom_range(0, 99) >= 73;
    end else if (idle_mode == 3) begin
      out_tready <= $urandom_range(0, 99) >= 24;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("timeout: no word moved for %0d cycles", idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_bar(logic [31:0] c, logic en, logic fin);
    int gap_pct;
    gap_pct = (idle_mode == 1) ? 73 : (idle_mode == 3) ? 24 : 0;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < gap_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tuser <= en;
    in_tlast <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      RegBuy: sb.buy_days = val[4:0];
      RegSell: sb.sell_days = val[4:0];
      default: sb.rise_max = val[13:0];
    endcase
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // walk segments: dips and recoveries, each window closed by a final bar
  task automatic random_bar();
    logic [63:0] step, nxt;
    logic        fin;
    if ($urandom_range(0, 99) < 12) begin
      send_bar($urandom, 1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0);
      return;
    end
    if (seg_left == 0) begin
      seg_left = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(6, 30);
      case ($urandom_range(0, 9))
        0: walk_price = $urandom_range(0, 50);
        1: walk_price = 32'hFFFF_FFFF - $urandom_range(0, 1000000);
        default: walk_price = $urandom_range(1000, 5000000);
      endcase
    end
    if ($urandom_range(0, 3) == 0) walk_down = !walk_down;
    step = (64'(walk_price) * $urandom_range(0, 1300)) / 10000 + $urandom_range(0, 2);
    if (walk_down) nxt = (64'(walk_price) > step) ? 64'(walk_price) - step : 64'd0;
    else nxt = 64'(walk_price) + step;
    walk_price = (nxt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nxt[31:0];
    seg_left--;
    fin = seg_left == 0;
    send_bar(walk_price, $urandom_range(0, 9) != 0, fin);
  endtask

  initial begin
    logic [4:0]  buy_set [8]  = '{5'd3, 5'd1, 5'd20, 5'd0, 5'd31, 5'd2, 5'd1, 5'd5};
    logic [4:0]  sell_set [8] = '{5'd1, 5'd1, 5'd20, 5'd0, 5'd31, 5'd3, 5'd2, 5'd1};
    logic [13:0] rise_set [8] = '{14'd990, 14'd0, 14'd10000, 14'd16383,
                                  14'd5000, 14'd1300, 14'd990, 14'd200};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: dip then cross, huge exit saturates equity
    for (int k = 0; k < 10; k++) send_bar(32'd10000 - 32'(k) * 100, 1'b1, 1'b0);
    send_bar(32'd9900, 1'b1, 1'b0);
    send_bar(32'hFFFF_FFFF, 1'b0, 1'b1);
    // dip then a final bar whose five bar sum only equals the last one, so no buy
    for (int k = 0; k < 8; k++) send_bar(32'd10000 - 32'(k) * 100, 1'b1, 1'b0);
    send_bar(32'd9700, 1'b1, 1'b1);
    send_bar(32'd0, 1'b1, 1'b0);
    send_bar(32'd0, 1'b1, 1'b1);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      cfg_write(RegBuy, 32'(buy_set[ph]));
      cfg_write(RegSell, 32'(sell_set[ph]));
      cfg_write(RegRise, 32'(rise_set[ph]));
      idle_mode = ph % 4;
      for (int n = 0; n < 150; n++) begin
        if (ph == 0 && n == 20) hold_req = 600;
        random_bar();
      end
      drain();
    end

    $display("sent %0d bars over 8 register settings, %0d results checked", words_in,
             sb.checked);
    $display("events: %0d buy, %0d sell, %0d forced, %0d buy+forced, %0d saturated",
             sb.n_buy, sb.n_sell, sb.n_forced, sb.n_both, sb.n_sat);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
